[hw/rtl/adpr_pkg.sv]
// ----------------------------------------------------------------------------
// adpr_pkg
// Shared constants, register codes and control types for the period mapper.
// ----------------------------------------------------------------------------
package adpr_pkg;

  localparam int ADC_BITS     = 12;
  localparam int FILTER_SHIFT = 3;
  localparam int PERIOD_W     = 16;
  localparam int NUM_W        = ADC_BITS + PERIOD_W;
  localparam int CNT_W        = $clog2(NUM_W);
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  localparam logic [ADC_BITS-1:0] ADC_MAX    = '1;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

  localparam logic [ADC_BITS-1:0] RST_WIN_LOW  = ADC_BITS'(100);
  localparam logic [ADC_BITS-1:0] RST_WIN_HIGH = ADC_BITS'(3300);
  localparam logic [PERIOD_W-1:0] RST_PER_LOW  = PERIOD_W'(1);
  localparam logic [PERIOD_W-1:0] RST_PER_HIGH = PERIOD_W'(10);
  localparam logic [PERIOD_W-1:0] RST_RAMP     = PERIOD_W'(1);
  localparam logic                RST_INVERT   = 1'b1;
  localparam logic [PERIOD_W-1:0] RST_PERIOD   = PERIOD_W'(6);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_LOW  = 3'd0,
    REG_WIN_HIGH = 3'd1,
    REG_PER_LOW  = 3'd2,
    REG_PER_HIGH = 3'd3,
    REG_RAMP     = 3'd4,
    REG_INVERT   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic accept;    // item taken: run the filter
    logic mul;       // window offset times period span
    logic div_step;  // one restoring divider step
    logic finish;    // slew update and result load
    logic reload;    // period back to midpoint after a write
  } adpr_cmd_t;

  typedef struct packed {
    logic cfg_hit;   // write landed on a known register
  } adpr_sts_t;

endpackage

[hw/rtl/adpr_ctrl.sv]
// ----------------------------------------------------------------------------
// adpr_ctrl
// Sequencer: input handshake, divider step count and result valid.
// ----------------------------------------------------------------------------
module adpr_ctrl import adpr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  adpr_sts_t sts,
  output adpr_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             reload_r, reload_nxt;
  logic             accept;
  logic             can_load;

  assign in_stall  = (state_r != ST_IDLE) || reload_r;
  assign accept    = in_valid && !in_stall;
  assign can_load  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.accept   = accept;
    cmd.mul      = (state_r == ST_MUL);
    cmd.div_step = (state_r == ST_DIV);
    cmd.finish   = (state_r == ST_DONE) && can_load;
    cmd.reload   = reload_r;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    reload_nxt    = sts.cfg_hit;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      reload_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      reload_r    <= reload_nxt;
    end
  end

endmodule

[hw/rtl/adpr_dp.sv]
// ----------------------------------------------------------------------------
// adpr_dp
// Datapath: settings, IIR filter, window map with restoring divider, slew.
// ----------------------------------------------------------------------------
module adpr_dp import adpr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [ADC_BITS-1:0]   in_adc_sample,
  input  adpr_cmd_t             cmd,
  output adpr_sts_t             sts,
  output logic [PERIOD_W-1:0]   out_period_ms,
  output logic [ADC_BITS-1:0]   out_filtered_level
);

  logic [ADC_BITS-1:0] win_low_r, win_high_r;
  logic [PERIOD_W-1:0] per_low_r, per_high_r, ramp_r;
  logic                invert_r;

  logic [ADC_BITS-1:0] acc_r, acc_nxt;
  logic [PERIOD_W-1:0] cur_r, cur_nxt;
  logic [ADC_BITS:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0]    quo_r, quo_nxt;
  logic [PERIOD_W-1:0] out_period_r;
  logic [ADC_BITS-1:0] out_level_r;

  logic                cfg_hit;
  logic [ADC_BITS-1:0] e_wlo, e_whi, span;
  logic [PERIOD_W-1:0] e_plo, e_phi, e_ramp, prange;
  logic [PERIOD_W:0]   mid_sum;

  logic signed [ADC_BITS+1:0] diff, fstep, fsum;
  logic [ADC_BITS-1:0] x, xoff;
  logic [NUM_W-1:0]    product;
  logic [ADC_BITS:0]   rem_sh;
  logic                ge;
  logic [PERIOD_W-1:0] t, target, gap, move;

  // settings after sanitizing
  always_comb begin
    if (win_low_r >= win_high_r) begin
      e_wlo = '0;
      e_whi = ADC_MAX;
    end else begin
      e_wlo = win_low_r;
      e_whi = win_high_r;
    end
    e_plo = (per_low_r == '0) ? PERIOD_W'(1) : per_low_r;
    if (per_high_r < e_plo) begin
      e_phi = (e_plo == PERIOD_MAX) ? PERIOD_MAX : e_plo + PERIOD_W'(1);
    end else begin
      e_phi = per_high_r;
    end
    e_ramp  = (ramp_r == '0) ? PERIOD_W'(1) : ramp_r;
    span    = e_whi - e_wlo;
    prange  = e_phi - e_plo;
    mid_sum = {1'b0, e_plo} + {1'b0, e_phi};
  end

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIN_LOW, REG_WIN_HIGH, REG_PER_LOW,
        REG_PER_HIGH, REG_RAMP, REG_INVERT: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end
  assign sts.cfg_hit = cfg_hit;

  // one-pole smoothing, floor shift then clamp to the converter range
  always_comb begin
    diff  = $signed({2'b00, in_adc_sample}) - $signed({2'b00, acc_r});
    fstep = diff >>> FILTER_SHIFT;
    fsum  = $signed({2'b00, acc_r}) + fstep;
    if (fsum[ADC_BITS+1]) begin
      acc_nxt = '0;
    end else if (fsum[ADC_BITS]) begin
      acc_nxt = ADC_MAX;
    end else begin
      acc_nxt = fsum[ADC_BITS-1:0];
    end
  end

  always_comb begin
    x = acc_r;
    if (x < e_wlo) x = e_wlo;
    if (x > e_whi) x = e_whi;
    xoff    = x - e_wlo;
    product = {{PERIOD_W{1'b0}}, xoff} * {{ADC_BITS{1'b0}}, prange};
  end

  // restoring divide, numerator bits shift out the top of quo_r
  always_comb begin
    rem_sh  = {rem_r[ADC_BITS-1:0], quo_r[NUM_W-1]};
    ge      = rem_sh >= {1'b0, span};
    rem_nxt = ge ? rem_sh - {1'b0, span} : rem_sh;
    quo_nxt = {quo_r[NUM_W-2:0], ge};
  end

  always_comb begin
    t      = quo_r[PERIOD_W-1:0];
    target = invert_r ? e_phi - t : e_plo + t;
    gap    = (cur_r < target) ? target - cur_r : cur_r - target;
    move   = (gap > e_ramp) ? e_ramp : gap;
    if (cur_r < target) begin
      cur_nxt = cur_r + move;
    end else begin
      cur_nxt = cur_r - move;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_low_r  <= RST_WIN_LOW;
      win_high_r <= RST_WIN_HIGH;
      per_low_r  <= RST_PER_LOW;
      per_high_r <= RST_PER_HIGH;
      ramp_r     <= RST_RAMP;
      invert_r   <= RST_INVERT;
      acc_r      <= '0;
      cur_r      <= RST_PERIOD;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_WIN_LOW:  win_low_r  <= cfg_data[ADC_BITS-1:0];
          REG_WIN_HIGH: win_high_r <= cfg_data[ADC_BITS-1:0];
          REG_PER_LOW:  per_low_r  <= cfg_data[PERIOD_W-1:0];
          REG_PER_HIGH: per_high_r <= cfg_data[PERIOD_W-1:0];
          REG_RAMP:     ramp_r     <= cfg_data[PERIOD_W-1:0];
          REG_INVERT:   invert_r   <= cfg_data[0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        acc_r <= '0;
      end else if (cmd.accept) begin
        acc_r <= acc_nxt;
      end
      // midpoint taken the cycle after the write, from the stored settings
      if (cmd.reload) begin
        cur_r <= mid_sum[PERIOD_W:1];
      end else if (cmd.finish) begin
        cur_r <= cur_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem_r <= '0;
      quo_r <= product;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (cmd.finish) begin
      out_period_r <= cur_nxt;
      out_level_r  <= acc_r;
    end
  end

  assign out_period_ms      = out_period_r;
  assign out_filtered_level = out_level_r;

endmodule

[hw/rtl/adc_to_period_ramp_mapper.sv]
// ----------------------------------------------------------------------------
// adc_to_period_ramp_mapper
// Smooths ADC samples, maps them onto a period range and slew-limits the result.
// ----------------------------------------------------------------------------
// Each accepted sample yields one result. The filter updates on the accepting
// edge; the multiply state, the restoring divider (one quotient bit per cycle
// over the 28-bit product) and the done state follow, the last doing the slew
// update and result load once the output register is free. in_stall is high
// while an item is in work, so a new sample is taken only after the last one
// is done. A finished result sits in the output register and the next sample
// is taken while it waits. A register write holds off input while the period
// reloads to the midpoint of the sanitized range. cfg_ready is always high;
// writes must go only while the block is idle, which the block does not enforce.
module adc_to_period_ramp_mapper import adpr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADC_BITS-1:0]   in_adc_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PERIOD_W-1:0]   out_period_ms,
  output logic [ADC_BITS-1:0]   out_filtered_level,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  adpr_cmd_t cmd;
  adpr_sts_t sts;
  logic      cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  adpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  adpr_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_adc_sample      (in_adc_sample),
    .cmd                (cmd),
    .sts                (sts),
    .out_period_ms      (out_period_ms),
    .out_filtered_level (out_filtered_level)
  );

endmodule
